FILE: rtl/core/hdlc_pkg.sv
// Shared types, constants and CRC helper for the HDLC deframer.
// No dependencies; used by hdlc_deframer_crc16_check.
package hdlc_pkg;

    localparam logic [7:0] FLAG_BYTE       = 8'h7E;
    localparam logic [7:0] ESC_BYTE        = 8'h7D;
    localparam logic [7:0] ESC_FLAG_CODE   = 8'h5E;
    localparam logic [7:0] ESC_ESC_CODE    = 8'h5D;
    localparam logic [7:0] MAX_LEN_DEFAULT = 8'd60;

    // result slots produced per input byte, and output queue depth
    localparam int RES_SLOTS  = 3;
    localparam int QUEUE_SIZE = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;
    localparam int KCNT_W     = 2;

    localparam int TDATA_W = 24;

    typedef enum logic
    {
        KIND_BYTE   = 1'b0,
        KIND_STATUS = 1'b1
    } item_kind_t;

    typedef struct packed
    {
        logic        in_frame;
        logic [7:0]  prev_raw;
        logic        held_valid;
        logic [7:0]  held_byte;
        logic [7:0]  tw0;        // older trailer byte
        logic [7:0]  tw1;        // newer trailer byte
        logic [7:0]  byte_count;
        logic [15:0] crc;
    } dfr_state_t;

    typedef struct packed
    {
        item_kind_t  kind;
        logic [7:0]  frame_byte;
        logic [7:0]  frame_length;
        logic        crc_ok;
        logic        truncated;
        logic        last;
    } result_t;

    // byte-wise CRC-CCITT (poly 0x1021)
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = {c[7:0], c[15:8]} ^ {8'h00, b};
        x = x ^ {12'h000, x[7:4]};
        x = x ^ {x[3:0], 12'h000};
        x = x ^ {3'b000, x[7:0], 5'b00000};
        return x;
    endfunction

    // held byte becomes final: oldest trailer byte moves into the CRC
    function automatic dfr_state_t finalize_held(input dfr_state_t s);
        dfr_state_t n;
        logic [7:0] done_before;
        n = s;
        done_before = s.byte_count - 8'd1;
        if (done_before >= 8'd2)
        begin
            n.crc = crc_step(s.crc, s.tw0);
        end
        n.tw0        = s.tw1;
        n.tw1        = s.held_byte;
        n.held_valid = 1'b0;
        return n;
    endfunction

endpackage

FILE: rtl/core/hdlc_deframer_crc16_check.sv
// HDLC byte deframer with CRC-CCITT check, top level.
// Depends on hdlc_pkg (types, constants, crc_step, finalize_held).

// One raw byte per input beat. A non-flag byte after a 0x7E flag opens a
// frame; 7D 5E and 7D 5D inside a frame fold back into 7E and 7D. Each frame
// byte leaves one beat late (tuser = 0), once the next raw byte shows it is
// final. A flag, or reaching max_frame_length (truncated), closes the frame
// with a status beat (tuser = 1) that carries length and crc_ok: CRC-CCITT,
// init 0, over all but the last two bytes, which hold the CRC little-endian.
// A closing flag also opens the next frame. tlast marks the final output beat
// caused by one input byte. Timing: all decoding and the CRC update happen in
// the accept cycle into a 4-entry output queue. One input byte per clock is
// taken while the queue holds at most one beat (s_tready high). One input
// byte yields 0 to 3 output beats; the output drains one beat per clock
// while m_tready is high, so the rate is 1 byte/clock while each byte yields
// at most one beat. Configuration: write cfg_wdata with cfg_wen while idle.
module hdlc_deframer_crc16_check
(
    input  logic                         clk,
    input  logic                         rst_n,
    // config register
    input  logic                         cfg_wen,
    input  logic [7:0]                   cfg_wdata,   // max_frame_length
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,     // [7:0] rx_byte
    // output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [hdlc_pkg::TDATA_W-1:0] m_tdata,     // [7:0] frame_byte,
                                                      // [15:8] frame_length,
                                                      // [16] crc_ok,
                                                      // [17] truncated, rest 0
    output logic [0:0]                   m_tuser,     // [0] item_kind
    output logic                         m_tlast      // last beat for this byte
);
    import hdlc_pkg::*;

    logic [7:0]  max_len_reg;
    dfr_state_t  st_reg;
    dfr_state_t  st_next;

    // output queue
    result_t                q_reg [QUEUE_SIZE];
    logic [QPTR_W-1:0]      wr_ptr_reg;
    logic [QPTR_W-1:0]      rd_ptr_reg;
    logic [QCNT_W-1:0]      q_cnt_reg;

    result_t                res [RES_SLOTS];
    logic [KCNT_W-1:0]      res_cnt;

    logic                   in_beat;
    logic                   out_beat;
    logic [7:0]             b;

    assign b        = s_tdata;
    assign s_tready = (q_cnt_reg <= QCNT_W'(1));
    assign in_beat  = s_tvalid & s_tready;
    assign m_tvalid = (q_cnt_reg != '0);
    assign out_beat = m_tvalid & m_tready;

    // ---------------------------------------------------------------
    // Decode of one raw byte: state update and up to three results
    // ---------------------------------------------------------------
    always_comb
    begin
        dfr_state_t s;
        logic       do_close;
        logic       trunc;
        logic       ok;

        s        = st_reg;
        res_cnt  = '0;
        do_close = 1'b0;
        trunc    = 1'b0;
        ok       = 1'b0;
        for (int i = 0; i < RES_SLOTS; i++)
        begin
            res[i] = '{kind: KIND_BYTE, frame_byte: 8'h00, frame_length: 8'h00,
                       crc_ok: 1'b0, truncated: 1'b0, last: 1'b0};
        end

        if (s.in_frame)
        begin
            if (b == FLAG_BYTE)
            begin
                do_close = 1'b1;
            end
            else
            begin
                if (s.prev_raw == ESC_BYTE && (b == ESC_FLAG_CODE || b == ESC_ESC_CODE))
                begin
                    // escaped byte rewrites the pending one
                    s.held_byte  = (b == ESC_FLAG_CODE) ? FLAG_BYTE : ESC_BYTE;
                    s.held_valid = 1'b1;
                end
                else
                begin
                    if (s.held_valid)
                    begin
                        res[res_cnt].frame_byte = s.held_byte;
                        res_cnt = res_cnt + KCNT_W'(1);
                        s = finalize_held(s);
                    end
                    s.held_byte  = b;
                    s.held_valid = 1'b1;
                    s.byte_count = s.byte_count + 8'd1;
                end
                if (s.byte_count >= max_len_reg)
                begin
                    do_close = 1'b1;
                    trunc    = 1'b1;
                end
            end
        end
        else if (s.prev_raw == FLAG_BYTE && b != FLAG_BYTE)
        begin
            s.in_frame   = 1'b1;
            s.held_byte  = b;
            s.held_valid = 1'b1;
            s.byte_count = 8'd1;
            s.crc        = 16'h0000;
            if (8'd1 >= max_len_reg)
            begin
                do_close = 1'b1;
                trunc    = 1'b1;
            end
        end

        if (do_close)
        begin
            if (s.held_valid)
            begin
                res[res_cnt].frame_byte = s.held_byte;
                res_cnt = res_cnt + KCNT_W'(1);
                s = finalize_held(s);
            end
            ok = (s.byte_count >= 8'd2) && (s.crc == {s.tw1, s.tw0});
            res[res_cnt].kind         = KIND_STATUS;
            res[res_cnt].frame_length = s.byte_count;
            res[res_cnt].crc_ok       = ok;
            res[res_cnt].truncated    = trunc;
            res_cnt = res_cnt + KCNT_W'(1);
            s.in_frame   = 1'b0;
            s.held_valid = 1'b0;
        end

        for (int i = 0; i < RES_SLOTS; i++)
        begin
            res[i].last = (KCNT_W'(i) == res_cnt - KCNT_W'(1));
        end

        s.prev_raw = b;
        st_next    = s;
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_DEFAULT;
            st_reg      <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                max_len_reg <= cfg_wdata;
            end
            if (in_beat)
            begin
                st_reg <= st_next;
            end
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (in_beat)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(res_cnt);
            end
            if (out_beat)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            q_cnt_reg <= q_cnt_reg
                         + (in_beat ? QCNT_W'(res_cnt) : QCNT_W'(0))
                         - (out_beat ? QCNT_W'(1) : QCNT_W'(0));
        end
    end

    // queue payload: each entry takes the result at its offset from wr_ptr
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_SIZE; i++)
        begin
            logic [QPTR_W-1:0] off;
            off = QPTR_W'(i) - wr_ptr_reg;
            if (in_beat && ({1'b0, off} < {1'b0, res_cnt}))
            begin
                q_reg[i] <= res[off];
            end
        end
    end

    result_t head;
    assign head    = q_reg[rd_ptr_reg];
    assign m_tdata = {6'b000000, head.truncated, head.crc_ok,
                      head.frame_length, head.frame_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= QCNT_W'(QUEUE_SIZE))
        else $error("output queue overflow");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("status beat not last for its input byte");

    a_byte_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[17:8] == 10'd0))
        else $error("frame byte beat carries status fields");

    a_held_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.held_valid |-> st_reg.in_frame)
        else $error("pending byte outside a frame");

endmodule

FILE: tb/hdlc_frame_checker.sv
// Scoreboard for the HDLC deframer: byte-level frame predictor plus beat checker.
// Holds hdlc_tb_pkg (beat type, and the CRC shared with the stimulus).
// Depends on hdlc_pkg for constants and the item kind enum.
package hdlc_tb_pkg;

    import hdlc_pkg::*;

    localparam logic [15:0] CCITT_POLY = 16'h1021;

    typedef struct
    {
        item_kind_t  kind;
        logic [7:0]  data;
        logic [7:0]  length;
        logic        crc_ok;
        logic        truncated;
        logic        last;
    } deframed_beat_t;

    // bit-serial CRC-CCITT, MSB first, one byte
    function automatic logic [15:0] ccitt_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            r = r[15] ? ((r << 1) ^ CCITT_POLY) : (r << 1);
        end
        return r;
    endfunction

endpackage

module hdlc_frame_checker
    import hdlc_pkg::*;
    import hdlc_tb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [7:0]          cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [TDATA_W-1:0]  m_tdata,
    input  logic [0:0]          m_tuser,
    input  logic                m_tlast,
    output int                  errors,
    output int                  outstanding
);

    logic [7:0]  limit_reg = MAX_LEN_DEFAULT;
    logic        framing   = 1'b0;
    logic [7:0]  prev_raw  = 8'h00;
    logic        held_ok   = 1'b0;
    logic [7:0]  held      = 8'h00;
    logic [7:0]  trail_old = 8'h00;
    logic [7:0]  trail_new = 8'h00;
    logic [7:0]  count     = 8'h00;
    logic [15:0] crc_acc   = 16'h0000;

    deframed_beat_t beats_due[$];
    deframed_beat_t step_beats[$];
    int mismatches = 0;
    int due_count  = 0;

    assign errors      = mismatches;
    assign outstanding = due_count;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // pending byte is final: oldest trailer byte shifts into the CRC
    task automatic release_held();
        logic [7:0]     done_before;
        deframed_beat_t bt;
        if (held_ok)
        begin
            done_before = count - 8'd1;
            if (done_before >= 8'd2)
            begin
                crc_acc = ccitt_update(crc_acc, trail_old);
            end
            trail_old    = trail_new;
            trail_new    = held;
            held_ok      = 1'b0;
            bt.kind      = KIND_BYTE;
            bt.data      = held;
            bt.length    = 8'h00;
            bt.crc_ok    = 1'b0;
            bt.truncated = 1'b0;
            bt.last      = 1'b0;
            step_beats.push_back(bt);
        end
    endtask

    task automatic close_frame(input logic trunc);
        deframed_beat_t bt;
        bt.kind      = KIND_STATUS;
        bt.data      = 8'h00;
        bt.length    = count;
        bt.crc_ok    = (count >= 8'd2) && (crc_acc == {trail_new, trail_old});
        bt.truncated = trunc;
        bt.last      = 1'b0;
        step_beats.push_back(bt);
        framing = 1'b0;
        held_ok = 1'b0;
    endtask

    // one raw byte in, zero to three beats queued
    task automatic deframe_byte(input logic [7:0] b);
        deframed_beat_t bt;
        step_beats.delete();
        if (framing)
        begin
            if (b == FLAG_BYTE)
            begin
                release_held();
                close_frame(1'b0);
            end
            else
            begin
                if (prev_raw == ESC_BYTE && (b == ESC_FLAG_CODE || b == ESC_ESC_CODE))
                begin
                    held    = (b == ESC_FLAG_CODE) ? FLAG_BYTE : ESC_BYTE;
                    held_ok = 1'b1;
                end
                else
                begin
                    release_held();
                    held    = b;
                    held_ok = 1'b1;
                    count   = count + 8'd1;
                end
                if (count >= limit_reg)
                begin
                    release_held();
                    close_frame(1'b1);
                end
            end
        end
        else if (prev_raw == FLAG_BYTE && b != FLAG_BYTE)
        begin
            framing = 1'b1;
            held    = b;
            held_ok = 1'b1;
            count   = 8'd1;
            crc_acc = 16'h0000;
            if (count >= limit_reg)
            begin
                release_held();
                close_frame(1'b1);
            end
        end
        prev_raw = b;
        foreach (step_beats[i])
        begin
            bt      = step_beats[i];
            bt.last = (i == step_beats.size() - 1);
            beats_due.push_back(bt);
        end
    endtask

    task automatic match_beat();
        deframed_beat_t want;
        if (beats_due.size() == 0)
        begin
            report_mismatch("beat with nothing due, frame_byte", m_tdata[7:0], 8'h00);
        end
        else
        begin
            want = beats_due.pop_front();
            if (m_tuser[0] !== want.kind)
                report_mismatch("item_kind", {7'd0, m_tuser[0]}, {7'd0, want.kind});
            if (m_tdata[7:0] !== want.data)
                report_mismatch("frame_byte", m_tdata[7:0], want.data);
            if (m_tdata[15:8] !== want.length)
                report_mismatch("frame_length", m_tdata[15:8], want.length);
            if (m_tdata[16] !== want.crc_ok)
                report_mismatch("crc_ok", {7'd0, m_tdata[16]}, {7'd0, want.crc_ok});
            if (m_tdata[17] !== want.truncated)
                report_mismatch("truncated", {7'd0, m_tdata[17]}, {7'd0, want.truncated});
            if (m_tdata[TDATA_W-1:18] !== '0)
                report_mismatch("tdata padding", {2'd0, m_tdata[TDATA_W-1:18]}, 8'h00);
            if (m_tlast !== want.last)
                report_mismatch("tlast", {7'd0, m_tlast}, {7'd0, want.last});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg = MAX_LEN_DEFAULT;
            framing   = 1'b0;
            prev_raw  = 8'h00;
            held_ok   = 1'b0;
            held      = 8'h00;
            trail_old = 8'h00;
            trail_new = 8'h00;
            count     = 8'h00;
            crc_acc   = 16'h0000;
            beats_due.delete();
        end
        else
        begin
            // a beat leaving now cannot stem from a byte accepted now
            if (m_tvalid && m_tready)
                match_beat();
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (cfg_wen)
                limit_reg = cfg_wdata;
        end
        due_count = beats_due.size();
    end

endmodule

FILE: tb/tb.sv
// Top-level testbench for hdlc_deframer_crc16_check: clock, reset, stimulus, verdict.
// Depends on hdlc_pkg and on hdlc_frame_checker.sv (hdlc_tb_pkg, hdlc_frame_checker).
module tb;

    import hdlc_pkg::*;
    import hdlc_tb_pkg::*;

    // Generous ceiling: raw bytes can each fan out to three beats behind a
    // heavily stalled receiver.
    localparam int CYCLE_LIMIT            = 400000;
    localparam int RANDOM_BYTES_PER_PHASE = 50;
    // beats leave a small output queue; extra wait for the block to settle
    localparam int SETTLE_CYCLES          = 4;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_wen   = 1'b0;
    logic [7:0]          cfg_wdata = 8'h00;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = 8'h00;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [0:0]          m_tuser;
    logic                m_tlast;

    int mismatches;
    int beats_pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    int cycle_count   = 0;
    bit line_open     = 1'b0;   // last raw byte on the line was a flag

    always #1 clk = ~clk;

    hdlc_deframer_crc16_check u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    hdlc_frame_checker u_chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (mismatches),
        .outstanding (beats_pending)
    );

    // Receiver: random back-pressure, rate set per phase.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // One raw byte on the input stream. Returns at the edge that accepted it,
    // so the next call either keeps tvalid high or drops it for a gap; tvalid
    // never gets two updates in the same step.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        line_open = (b == FLAG_BYTE);
    endtask

    // Payload + little-endian FCS, byte-stuffed, then the closing flag.
    // Caller takes care of the opening flag.
    task automatic send_frame(input logic [7:0] body[$], input bit corrupt);
        logic [15:0] fcs;
        logic [7:0]  framed[$];
        fcs = 16'h0000;
        foreach (body[i])
        begin
            fcs = ccitt_update(fcs, body[i]);
        end
        if (corrupt)
            fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
        framed = body;
        framed.push_back(fcs[7:0]);
        framed.push_back(fcs[15:8]);
        foreach (framed[i])
        begin
            if (framed[i] == FLAG_BYTE || framed[i] == ESC_BYTE)
            begin
                send_byte(ESC_BYTE);
                send_byte(framed[i] == FLAG_BYTE ? ESC_FLAG_CODE : ESC_ESC_CODE);
            end
            else
            begin
                send_byte(framed[i]);
            end
        end
        send_byte(FLAG_BYTE);
    endtask

    // Length limit changes only once the block has drained.
    task automatic write_limit(input logic [7:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (beats_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // payload bytes lean on the HDLC control codes to exercise stuffing
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 7))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            2:       return $urandom_range(0, 1) ? ESC_FLAG_CODE : ESC_ESC_CODE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random traffic: mostly clean frames with random bodies, some line noise
    // and some frames cut off by a dangling escape.
    task automatic run_phase(input logic [7:0] limit, input int s_pct, input int r_pct,
                             input bit long_first);
        int          first;
        int          pick;
        int          n;
        logic [7:0]  body[$];
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_limit(limit);
        if (long_first)
        begin
            // overruns the limit: truncated status, tail bytes become idle noise
            body.delete();
            repeat (int'(limit) + 3) body.push_back(payload_byte());
            if (!line_open)
                send_byte(FLAG_BYTE);
            send_frame(body, 1'b0);
        end
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES_PER_PHASE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                body.delete();
                n = ($urandom_range(0, 24) == 0) ? $urandom_range(0, int'(limit) + 2)
                                                 : $urandom_range(0, 8);
                repeat (n) body.push_back(payload_byte());
                // usually let the closing flag of the last frame open this one
                if (!line_open || $urandom_range(0, 4) == 0)
                    send_byte(FLAG_BYTE);
                send_frame(body, $urandom_range(0, 6) == 0);
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                if (!line_open)
                    send_byte(FLAG_BYTE);
                repeat ($urandom_range(0, 5)) send_byte(payload_byte());
                send_byte(ESC_BYTE);
                send_byte(FLAG_BYTE);
            end
        end
    endtask

    initial
    begin
        logic [7:0] body[$];

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 12;
        recv_idle_pct = 47;

        // --- directed, default limit ---
        // back-to-back flags while idle: nothing comes out
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        // one-byte frame: too short for an FCS, closing flag opens the next
        send_byte(8'h41);
        send_byte(FLAG_BYTE);
        // escape as the very first byte, both escape codes, good FCS
        body = '{FLAG_BYTE, ESC_BYTE};
        send_frame(body, 1'b0);
        // field extremes
        body = '{8'h00, 8'hFF};
        send_frame(body, 1'b0);
        // empty body: FCS only, two bytes of zero
        body.delete();
        send_frame(body, 1'b0);

        // --- directed, smallest limit ---
        write_limit(8'd2);
        // truncated after two bytes, third byte is idle noise
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(FLAG_BYTE);
        // truncated yet FCS matches
        body.delete();
        send_frame(body, 1'b0);
        // folded escape keeps the count at one
        send_byte(ESC_BYTE);
        send_byte(ESC_FLAG_CODE);
        send_byte(FLAG_BYTE);

        // --- random phases: receiver-heavy idling, sender-heavy, none ---
        run_phase(8'($urandom_range(3, 20)), 12, 47, 1'b1);
        run_phase(8'd255, 47, 12, 1'b0);
        run_phase(8'($urandom_range(21, 254)), 0, 0, 1'b0);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (beats_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
